// ===== sv/es2c_pkg.sv =====
// es2c_pkg: widths, calendar constants and reciprocal multipliers
// for the epoch seconds to calendar pipeline; no dependencies
`default_nettype none

package es2c_pkg;

  localparam int unsigned SEC_W   = 32;
  localparam int unsigned SECF_W  = 6;
  localparam int unsigned MINF_W  = 6;
  localparam int unsigned HOURF_W = 5;
  localparam int unsigned DAYF_W  = 5;
  localparam int unsigned MONF_W  = 4;
  localparam int unsigned YEARF_W = 12;

  localparam int unsigned SEC_PER_DAY = 86400;
  localparam int unsigned DAY_PRESH   = 7;
  localparam int unsigned DAY_DIV     = SEC_PER_DAY >> DAY_PRESH;
  localparam int unsigned SEC_PER_MIN = 60;
  localparam int unsigned MIN_PER_HR  = 60;
  localparam int unsigned JDN_EPOCH   = 2440588;
  localparam int unsigned JDN_OFS     = 32044;
  localparam int unsigned A_BASE      = JDN_EPOCH + JDN_OFS;
  localparam int unsigned B_DIV       = 146097;
  localparam int unsigned D_DIV       = 1461;
  localparam int unsigned M_DIV       = 153;
  localparam int unsigned T_DIV       = 5;
  localparam int unsigned YEAR_MUL    = 100;
  localparam int unsigned YEAR_BIAS   = 4800;
  localparam int unsigned MONTH_WRAP  = 10;
  localparam int unsigned MONTH_LATE  = 9;
  localparam int unsigned MONTH_EARLY = 3;

  // shift amounts: operand bits plus ceil(log2(divisor))
  localparam int unsigned DAY_SH  = 35;
  localparam int unsigned B_SH    = 42;
  localparam int unsigned MIN_SH  = 23;
  localparam int unsigned HOUR_SH = 17;
  localparam int unsigned D_SH    = 31;
  localparam int unsigned M_SH    = 19;
  localparam int unsigned T_SH    = 14;

  // rounded-up reciprocals, exact quotient over the operand range
  localparam logic [25:0] DAY_MUL =
    26'(((64'd1 << DAY_SH) + 64'(DAY_DIV) - 64'd1) / 64'(DAY_DIV));
  localparam logic [24:0] B_MUL =
    25'(((64'd1 << B_SH) + 64'(B_DIV) - 64'd1) / 64'(B_DIV));
  localparam logic [17:0] MIN_MUL =
    18'(((64'd1 << MIN_SH) + 64'(SEC_PER_MIN) - 64'd1) / 64'(SEC_PER_MIN));
  localparam logic [11:0] HOUR_MUL =
    12'(((64'd1 << HOUR_SH) + 64'(MIN_PER_HR) - 64'd1) / 64'(MIN_PER_HR));
  localparam logic [20:0] D_MUL =
    21'(((64'd1 << D_SH) + 64'(D_DIV) - 64'd1) / 64'(D_DIV));
  localparam logic [11:0] M_MUL =
    12'(((64'd1 << M_SH) + 64'(M_DIV) - 64'd1) / 64'(M_DIV));
  localparam logic [11:0] T_MUL =
    12'(((64'd1 << T_SH) + 64'(T_DIV) - 64'd1) / 64'(T_DIV));

endpackage

`default_nettype wire

// ===== sv/es2c_in_if.sv =====
// es2c_in_if: valid/ready channel carrying one seconds count
// depends on es2c_pkg
`default_nettype none

interface es2c_in_if;
  import es2c_pkg::*;

  logic             valid;
  logic             ready;
  logic [SEC_W-1:0] seconds_count;

  modport source (output valid, output seconds_count, input ready);
  modport sink (input valid, input seconds_count, output ready);
endinterface

`default_nettype wire

// ===== sv/es2c_out_if.sv =====
// es2c_out_if: valid/ready channel carrying the calendar date and time of day
// depends on es2c_pkg
`default_nettype none

interface es2c_out_if;
  import es2c_pkg::*;

  logic               valid;
  logic               ready;
  logic [SECF_W-1:0]  second_of_minute;
  logic [MINF_W-1:0]  minute_of_hour;
  logic [HOURF_W-1:0] hour_of_day;
  logic [DAYF_W-1:0]  day_of_month;
  logic [MONF_W-1:0]  month_of_year;
  logic [YEARF_W-1:0] calendar_year;

  modport source (output valid, output second_of_minute, output minute_of_hour,
                  output hour_of_day, output day_of_month, output month_of_year,
                  output calendar_year, input ready);
  modport sink (input valid, input second_of_minute, input minute_of_hour,
                input hour_of_day, input day_of_month, input month_of_year,
                input calendar_year, output ready);
endinterface

`default_nettype wire

// ===== sv/epoch_seconds_to_calendar_unit.sv =====
// epoch_seconds_to_calendar_unit: epoch seconds count to Gregorian date and time of day
// depends on es2c_pkg, es2c_in_if, es2c_out_if
//
// usage:
//   stamp    valid/ready sink, one 32-bit seconds count since 1970-01-01 00:00:00
//   calendar valid/ready source, second, minute, hour, day, month and year
//   one transfer on stamp yields exactly one transfer on calendar, in order
//   nine register stages; one count is taken every cycle while calendar is
//   not stalled
//   every constant division is a reciprocal multiply spread over the stages;
//   the widest product is 25 by 26 bits, in the first stage
//   when calendar stalls with a result waiting, the whole pipeline holds and
//   stamp.ready drops; bubbles travel with their valid bits, nothing is lost
//   or repeated
//   rst (synchronous, active high) empties the pipeline; no other state exists
`default_nettype none

module epoch_seconds_to_calendar_unit (
  input  wire logic    clk,
  input  wire logic    rst,
  es2c_in_if.sink      stamp,
  es2c_out_if.source   calendar
);
  import es2c_pkg::*;

  logic adv;
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9;

  // stage 1
  logic [50:0] p_day;
  logic [31:0] cnt1;
  logic [15:0] dq1;
  // stage 2
  logic [31:0] dsec;
  logic [16:0] tod2;
  logic [21:0] a2;
  // stage 3
  logic [48:0] p_b;
  logic [34:0] p_min;
  logic [16:0] tod3;
  logic [21:0] a3;
  logic [6:0]  b3;
  logic [10:0] mins3;
  // stage 4
  logic [23:0] bp;
  logic [22:0] p_hr;
  logic [16:0] min_sec;
  logic [17:0] c4;
  logic [6:0]  b4;
  logic [10:0] mins4;
  logic [5:0]  sec4;
  logic [4:0]  hour4;
  // stage 5
  logic [40:0] p_d;
  logic [10:0] hr_min;
  logic [17:0] c5;
  logic [9:0]  d5;
  logic [6:0]  b5;
  logic [5:0]  sec5, minute5;
  logic [4:0]  hour5;
  // stage 6
  logic [20:0] dp;
  logic [18:0] e_full;
  logic [8:0]  e6;
  logic [9:0]  d6;
  logic [6:0]  b6;
  logic [5:0]  sec6, minute6;
  logic [4:0]  hour6;
  // stage 7
  logic [10:0] xm;
  logic [22:0] p_m;
  logic [8:0]  e7;
  logic [9:0]  d7;
  logic [6:0]  b7;
  logic [3:0]  m7;
  logic [5:0]  sec7, minute7;
  logic [4:0]  hour7;
  // stage 8
  logic        late;
  logic [15:0] ycalc;
  logic [10:0] t8;
  logic [8:0]  e8;
  logic [3:0]  month8;
  logic [11:0] year8;
  logic [5:0]  sec8, minute8;
  logic [4:0]  hour8;
  // stage 9
  logic [22:0] p_t;
  logic [8:0]  day_full;
  logic [4:0]  day9;
  logic [3:0]  month9;
  logic [11:0] year9;
  logic [5:0]  sec9, minute9;
  logic [4:0]  hour9;

  assign adv         = !v9 || calendar.ready;
  assign stamp.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9} <= '0;
    end else if (adv) begin
      v1 <= stamp.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
      v9 <= v8;
    end
  end

  always_comb begin
    p_day   = 51'(stamp.seconds_count[SEC_W-1:DAY_PRESH]) * 51'(DAY_MUL);
    dsec    = 32'(dq1) * 32'(SEC_PER_DAY);
    p_b     = 49'({a2, 2'b11}) * 49'(B_MUL);
    p_min   = 35'(tod2) * 35'(MIN_MUL);
    bp      = 24'(b3) * 24'(B_DIV);
    min_sec = 17'(mins3) * 17'(SEC_PER_MIN);
    p_hr    = 23'(mins3) * 23'(HOUR_MUL);
    p_d     = 41'({c4, 2'b11}) * 41'(D_MUL);
    hr_min  = 11'(hour4) * 11'(MIN_PER_HR);
    dp      = 21'(d5) * 21'(D_DIV);
    e_full  = 19'(c5) - 19'(dp[20:2]);
    xm      = 11'(e6) * 11'(T_DIV) + 11'd2;
    p_m     = 23'(xm) * 23'(M_MUL);
    late    = (m7 >= 4'(MONTH_WRAP));
    ycalc   = 16'(b7) * 16'(YEAR_MUL) + 16'(d7) + 16'(late) - 16'(YEAR_BIAS);
    p_t     = 23'(t8) * 23'(T_MUL);
    day_full = e8 - 9'(p_t[22:T_SH]) + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // day count and carry of the raw count
      cnt1    <= stamp.seconds_count;
      dq1     <= p_day[DAY_SH+15:DAY_SH];
      // time of day, start of the julian chain
      tod2    <= 17'(cnt1 - dsec);
      a2      <= 22'(dq1) + 22'(A_BASE);
      // centuries, minutes of the day
      tod3    <= tod2;
      a3      <= a2;
      b3      <= p_b[B_SH+6:B_SH];
      mins3   <= p_min[MIN_SH+10:MIN_SH];
      // day within the century, seconds, hours
      c4      <= 18'(a3 - 22'(bp[23:2]));
      b4      <= b3;
      mins4   <= mins3;
      sec4    <= 6'(tod3 - min_sec);
      hour4   <= p_hr[HOUR_SH+4:HOUR_SH];
      // years within the century, minutes
      c5      <= c4;
      d5      <= p_d[D_SH+9:D_SH];
      b5      <= b4;
      sec5    <= sec4;
      minute5 <= 6'(mins4 - hr_min);
      hour5   <= hour4;
      // day of the year, counted from march
      e6      <= e_full[8:0];
      d6      <= d5;
      b6      <= b5;
      sec6    <= sec5;
      minute6 <= minute5;
      hour6   <= hour5;
      // month index counted from march
      e7      <= e6;
      d7      <= d6;
      b7      <= b6;
      m7      <= p_m[M_SH+3:M_SH];
      sec7    <= sec6;
      minute7 <= minute6;
      hour7   <= hour6;
      // month and year
      e8      <= e7;
      t8      <= 11'(m7) * 11'(M_DIV) + 11'd2;
      month8  <= late ? (m7 - 4'(MONTH_LATE)) : (m7 + 4'(MONTH_EARLY));
      year8   <= ycalc[11:0];
      sec8    <= sec7;
      minute8 <= minute7;
      hour8   <= hour7;
      // day of the month, output register
      day9    <= day_full[4:0];
      month9  <= month8;
      year9   <= year8;
      sec9    <= sec8;
      minute9 <= minute8;
      hour9   <= hour8;
    end
  end

  assign calendar.valid            = v9;
  assign calendar.second_of_minute = sec9;
  assign calendar.minute_of_hour   = minute9;
  assign calendar.hour_of_day      = hour9;
  assign calendar.day_of_month     = day9;
  assign calendar.month_of_year    = month9;
  assign calendar.calendar_year    = year9;

endmodule

`default_nettype wire
